[hw/rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } deq_op_t;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque: push or pop at either end, one status beat per request
//
//   channel  dir  ports                                          beat
//   in       in   in_valid in_stall in_req_type in_push_word     one request
//   out      out  out_valid out_stall out_status out_popped_word one result
//                 out_entry_count
//
// one request per cycle; its result shows in the output register the next
// cycle. the entries live in a row of cells that shifts at a front push or
// front pop, so the front entry is always in the first cell and the back
// entry is the last valid cell. synchronous reset empties the row at once.
// a stalled result holds the output register and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [DATA_WIDTH-1:0] in_push_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [DATA_WIDTH-1:0] out_popped_word,
  output logic      [COUNT_W-1:0]    out_entry_count
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_WIDTH-1:0] out_popped_word_r;
  logic [COUNT_W-1:0]    out_entry_count_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  is_push;
  logic                  ok;
  logic [STATUS_W-1:0]   status;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] popped;
  logic [WIDE_W-1:0]     count_ext;
  deq_op_t               op;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign is_push  = (in_req_type == REQ_PUSH_FRONT) || (in_req_type == REQ_PUSH_BACK);
  assign ok       = is_push ? ~full : ~empty;

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  always_comb begin
    op        = '0;
    status    = ST_OK;
    popped    = '0;
    count_nxt = count_r;
    unique case (in_req_type)
      REQ_PUSH_FRONT: begin
        op.push_front = accept & ok;
        if (!ok) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        op.push_back = accept & ok;
        if (!ok) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        op.pop_front = accept & ok;
        if (!ok) begin
          status = ST_EMPTY;
        end else begin
          popped    = cell_data[0];
          count_nxt = count_r - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        op.pop_back = accept & ok;
        if (!ok) begin
          status = ST_EMPTY;
        end else begin
          popped    = back_word;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign count_ext = WIDE_W'(count_nxt);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic                  prev_valid;
    logic [DATA_WIDTH-1:0] next_data;
    logic                  next_valid;

    if (i == 0) begin : g_first
      assign prev_data  = in_push_word;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .push_word  (in_push_word),
      .prev_data  (prev_data),
      .prev_valid (prev_valid),
      .next_data  (next_data),
      .next_valid (next_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .tail_word  (cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r      <= status;
      out_popped_word_r <= popped;
      out_entry_count_r <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_popped_word = out_popped_word_r;
  assign out_entry_count = out_entry_count_r;

endmodule

`default_nettype wire

[hw/rtl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// one entry of the shifting row; the front entry sits in the first cell
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire deq_op_t               op,
  input  wire logic [DATA_WIDTH-1:0] push_word,
  input  wire logic [DATA_WIDTH-1:0] prev_data,
  input  wire logic                  prev_valid,
  input  wire logic [DATA_WIDTH-1:0] next_data,
  input  wire logic                  next_valid,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       valid,
  output logic      [DATA_WIDTH-1:0] tail_word
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  valid_r;
  logic                  valid_nxt;
  logic                  tail;

  assign tail = valid_r & ~next_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (op.push_front) begin
      data_nxt  = prev_data;
      valid_nxt = prev_valid;
    end else if (op.push_back) begin
      if (!valid_r && prev_valid) begin
        data_nxt  = push_word;
        valid_nxt = 1'b1;
      end
    end else if (op.pop_front) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end else if (op.pop_back) begin
      if (tail) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign valid     = valid_r;
  assign tail_word = tail ? data_r : '0;

endmodule

`default_nettype wire

[hw/rtl/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks of the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [STATUS_W-1:0]   out_status,
  input wire logic [DATA_WIDTH-1:0] out_popped_word,
  input wire logic [COUNT_W-1:0]    out_entry_count
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [WIDE_W-1:0] DEPTH_EXT = WIDE_W'(DEPTH);
  localparam logic [COUNT_W-1:0] FULL_COUNT = DEPTH_EXT[COUNT_W-1:0];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_popped_word) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_FULL) |->
      out_popped_word == '0)
    else $error("refused request returned a word");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with entries stored");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == FULL_COUNT)
    else $error("full status without a full queue");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_popped_word (out_popped_word),
  .out_entry_count (out_entry_count)
);

`default_nettype wire
